// File: design/ultrasonic_echo_ranger_assert.svh
// ----------------------------------------------------------------------------
// ultrasonic echo ranger assertion macros
// shared property forms for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// same-cycle implication
`define UER_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// field widths, register indexes and reset values of the echo ranger
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int TRIG_W     = 16;
	localparam int SPEED_W    = 10;
	localparam int DIV_W      = 20;
	localparam int DIST_W     = 16;
	localparam int PULSE_W    = 24;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = 2'd2;

	localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 16'd80;
	localparam logic [SPEED_W-1:0] SPEED_FACTOR_RST  = 10'd343;
	localparam logic [DIV_W-1:0]   SCALE_DIVISOR_RST = 20'd320000;

	localparam logic [DIST_W-1:0]  DIST_MAX  = 16'hFFFF;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 24'hFFFFFF;

endpackage

`default_nettype wire

// File: design/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// shared scaling unit: one multiply, then restoring division a bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_div #(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [COUNT_WIDTH-1:0]       width,
	input  wire logic [uer_pkg::SPEED_W-1:0]  speed,
	input  wire logic [uer_pkg::DIV_W-1:0]    divisor,
	output logic                              done,
	output logic [uer_pkg::DIST_W-1:0]        quotient
);

	localparam int PROD_W = COUNT_WIDTH + uer_pkg::SPEED_W;
	localparam int STEP_W = $clog2(PROD_W);

	typedef enum logic [1:0] {
		D_IDLE,
		D_MUL,
		D_DIV
	} div_state_t;

	div_state_t                    state_q;
	logic [STEP_W-1:0]             step_q;
	logic [PROD_W-1:0]             prod_q;
	logic [uer_pkg::DIV_W-1:0]     rem_q;
	logic [uer_pkg::DIST_W-1:0]    quo_q;
	logic                          sat_q;
	logic                          done_q;
	logic [uer_pkg::DIST_W-1:0]    res_q;

	logic [uer_pkg::DIV_W:0]       trial;
	logic                          ge;
	logic [uer_pkg::DIV_W:0]       rem_nx;

	// one subtract and compare per quotient bit
	always_comb begin
		trial  = {rem_q, prod_q[PROD_W-1]};
		ge     = trial >= {1'b0, divisor};
		rem_nx = ge ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					prod_q  <= PROD_W'(width) * PROD_W'(speed);
					rem_q   <= '0;
					quo_q   <= '0;
					sat_q   <= 1'b0;
					step_q  <= '0;
					state_q <= D_DIV;
				end
				D_DIV: begin
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
					rem_q  <= rem_nx[uer_pkg::DIV_W-1:0];
					quo_q  <= {quo_q[uer_pkg::DIST_W-2:0], ge};
					// a bit shifted out of the top means the result exceeds 16 bits
					sat_q  <= sat_q | quo_q[uer_pkg::DIST_W-1];
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(PROD_W - 1)) begin
						res_q   <= (sat_q | quo_q[uer_pkg::DIST_W-1]) ? uer_pkg::DIST_MAX
							: {quo_q[uer_pkg::DIST_W-2:0], ge};
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = res_q;

endmodule

`default_nettype wire

// File: design/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// ping/echo distance measurement with a shared multiply-divide scaling unit
// ----------------------------------------------------------------------------
// Each input item is one clock tick of the sensor: a start request and the
// sampled echo level. Every item gives exactly one result item with the
// trigger level, busy, done, the held distance, the echo width and the
// overflow flag. An ordinary tick item goes straight to the result register;
// the block takes the next item in the following cycle unless a result is
// held. The item that sees the falling edge of the echo is accepted, then
// the width by speed product is formed, the restoring division makes one
// quotient bit per cycle on a single shared subtractor, and the result is
// loaded; until then in_stall stays high. The configuration port is always
// ready; the user must see that registers are written only while no item
// is in flight, which the block does not enforce. A zero divisor saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// tick items in
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            start_req,
	input  wire logic                            echo,
	// result items out
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 trigger_out,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [uer_pkg::DIST_W-1:0]           distance_cm,
	output logic [uer_pkg::PULSE_W-1:0]          pulse_ticks,
	output logic                                 overflow,
	// register writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// width used to cap the shown count whatever COUNT_WIDTH is
	localparam int WIDE_W = (COUNT_WIDTH > uer_pkg::PULSE_W) ? COUNT_WIDTH : uer_pkg::PULSE_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	// configuration
	logic [uer_pkg::TRIG_W-1:0]  trig_ticks_q;
	logic [uer_pkg::SPEED_W-1:0] speed_q;
	logic [uer_pkg::DIV_W-1:0]   divisor_q;

	// measurement state
	phase_t                      phase_q;
	logic [uer_pkg::TRIG_W-1:0]  trig_cnt_q;
	logic [COUNT_WIDTH-1:0]      width_q;
	logic                        echo_prev_q;
	logic [uer_pkg::DIST_W-1:0]  dist_hold_q;
	logic                        ovf_hold_q;
	logic                        pend_q;       // completing item waits on the scaling unit

	// output register
	logic                        out_valid_q;
	logic                        trig_out_q;
	logic                        busy_out_q;
	logic                        done_out_q;
	logic [uer_pkg::DIST_W-1:0]  dist_out_q;
	logic [uer_pkg::PULSE_W-1:0] pulse_out_q;
	logic                        ovf_out_q;

	// next state
	phase_t                      phase_d;
	logic [uer_pkg::TRIG_W-1:0]  trig_cnt_d;
	logic [COUNT_WIDTH-1:0]      width_d;
	logic                        finish;
	logic                        accept;
	logic [WIDE_W-1:0]           width_ext;
	logic [uer_pkg::PULSE_W-1:0] shown;

	logic                        div_done;
	logic [uer_pkg::DIST_W-1:0]  div_quot;

	// stall while the scaling unit runs or while the result register is held
	assign in_stall  = pend_q | (out_valid_q & out_stall);
	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		phase_d    = phase_q;
		trig_cnt_d = trig_cnt_q;
		width_d    = width_q;
		finish     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d    = PH_TRIG;
					trig_cnt_d = '0;
				end
			end
			PH_TRIG: begin
				// a length of zero still gives one trigger tick
				trig_cnt_d = trig_cnt_q + uer_pkg::TRIG_W'(1);
				if (trig_cnt_d >= trig_ticks_q) begin
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				// a level already high is not an edge
				if (echo && !echo_prev_q) begin
					phase_d = PH_MEAS;
					width_d = COUNT_WIDTH'(1);
				end
			end
			PH_MEAS: begin
				if (echo) begin
					if (width_q != CNT_MAX) begin
						width_d = width_q + COUNT_WIDTH'(1);
					end
				end else begin
					finish  = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// shown count, capped to the field width
	always_comb begin
		width_ext = WIDE_W'(width_d);
		shown     = (width_ext > WIDE_W'(uer_pkg::PULSE_MAX)) ? uer_pkg::PULSE_MAX
			: width_ext[uer_pkg::PULSE_W-1:0];
	end

	uer_div #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept & finish),
		.width    (width_q),
		.speed    (speed_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= uer_pkg::TRIGGER_TICKS_RST;
			speed_q      <= uer_pkg::SPEED_FACTOR_RST;
			divisor_q    <= uer_pkg::SCALE_DIVISOR_RST;
			phase_q      <= PH_IDLE;
			trig_cnt_q   <= '0;
			width_q      <= '0;
			echo_prev_q  <= 1'b0;
			dist_hold_q  <= '0;
			ovf_hold_q   <= 1'b0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					uer_pkg::REG_TRIGGER_TICKS: trig_ticks_q <= cfg_data[uer_pkg::TRIG_W-1:0];
					uer_pkg::REG_SPEED_FACTOR:  speed_q      <= cfg_data[uer_pkg::SPEED_W-1:0];
					uer_pkg::REG_SCALE_DIVISOR: divisor_q    <= cfg_data[uer_pkg::DIV_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				phase_q     <= phase_d;
				trig_cnt_q  <= trig_cnt_d;
				width_q     <= width_d;
				echo_prev_q <= echo;
				if (finish) begin
					// result waits for the scaled distance
					ovf_hold_q <= (width_q == CNT_MAX);
					pend_q     <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
					trig_out_q  <= (phase_d == PH_TRIG);
					busy_out_q  <= (phase_d != PH_IDLE);
					done_out_q  <= 1'b0;
					dist_out_q  <= dist_hold_q;
					pulse_out_q <= shown;
					ovf_out_q   <= ovf_hold_q;
				end
			end

			// distance ready: show the completing item
			if (div_done) begin
				pend_q      <= 1'b0;
				dist_hold_q <= div_quot;
				out_valid_q <= 1'b1;
				trig_out_q  <= 1'b0;
				busy_out_q  <= 1'b0;
				done_out_q  <= 1'b1;
				dist_out_q  <= div_quot;
				pulse_out_q <= shown;
				ovf_out_q   <= ovf_hold_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign trigger_out = trig_out_q;
	assign busy_res    = busy_out_q;
	assign done_res    = done_out_q;
	assign distance_cm = dist_out_q;
	assign pulse_ticks = pulse_out_q;
	assign overflow    = ovf_out_q;

endmodule

`default_nettype wire

// File: design/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// port-level checks on the echo ranger, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_echo_ranger_assert.svh"

module uer_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_stall,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic                        trigger_out,
	input  wire logic                        busy_res,
	input  wire logic                        done_res,
	input  wire logic [uer_pkg::DIST_W-1:0]  distance_cm
);

	// a finished measurement leaves the ranger idle
	`UER_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res && !trigger_out, "done while busy")

	// the trigger only fires inside a measurement
	`UER_ASSERT_NOW(a_trig_busy, out_valid && trigger_out, busy_res, "trigger while idle")

	// a held result blocks new items
	`UER_ASSERT_NOW(a_held_stall, out_valid && out_stall, in_stall, "item taken over a held result")

	// a held result keeps its distance
	`UER_ASSERT_NEXT(a_held_stable, out_valid && out_stall, out_valid && $stable(distance_cm),
		"held result changed")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.trigger_out (trigger_out),
	.busy_res    (busy_res),
	.done_res    (done_res),
	.distance_cm (distance_cm)
);

`default_nettype wire

// File: tb/tb_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger
// self-checking bench for the ping/echo ranger: every tick item is predicted
// by a cycle model of the ranging sequence and its result item is compared
// field by field, under several register settings and idling patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;

	// counter width of the block under test
	localparam int CNT_W = 16;
	localparam logic [31:0] WIDTH_SAT = 32'((64'd1 << CNT_W) - 1);
	// index with no register behind it, writes to it must be ignored
	localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// pause after the last result before a register write or the end
	localparam int SETTLE_CYCLES = CNT_W + 16;
	localparam int MAX_PRINTS = 100;

	typedef enum logic [1:0] {RNG_IDLE, RNG_TRIG, RNG_WAIT, RNG_MEAS} ranger_phase_t;

	typedef struct packed {
		logic start;
		logic echo;
	} tick_t;

	typedef struct packed {
		logic                        trig;
		logic                        busy;
		logic                        done;
		logic [uer_pkg::DIST_W-1:0]  distance;
		logic [uer_pkg::PULSE_W-1:0] pulse;
		logic                        ovf;
	} tick_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block ports; the inputs driven here are known from time zero
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            start_req = 1'b0;
	logic                            echo = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            trigger_out;
	logic                            busy_res;
	logic                            done_res;
	logic [uer_pkg::DIST_W-1:0]      distance_cm;
	logic [uer_pkg::PULSE_W-1:0]     pulse_ticks;
	logic                            overflow;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// ranger model: registers
	logic [uer_pkg::TRIG_W-1:0]  trig_len = uer_pkg::TRIGGER_TICKS_RST;
	logic [uer_pkg::SPEED_W-1:0] speed = uer_pkg::SPEED_FACTOR_RST;
	logic [uer_pkg::DIV_W-1:0]   divisor = uer_pkg::SCALE_DIVISOR_RST;

	// ranger model: state
	ranger_phase_t               rng_phase = RNG_IDLE;
	logic [uer_pkg::TRIG_W-1:0]  trig_count = '0;
	logic [31:0]                 width_count = '0;
	logic                        echo_last = 1'b0;
	logic [uer_pkg::DIST_W-1:0]  dist_hold = '0;
	logic                        ovf_hold = 1'b0;

	// pending tick items and predicted result items
	tick_t        tick_q[$];
	tick_result_t predicted_q[$];
	tick_t        next_tick;

	// idling controls, percentages out of a hundred
	int   gap_pct = 0;
	int   stall_pct = 0;
	bit   calm = 1'b0;
	bit   in_taken = 1'b0;

	int   mismatch_count = 0;
	int   ticks_queued = 0;

	int gap_plan[4]   = '{0, 80, 0, 34};
	int stall_plan[4] = '{0, 0, 80, 34};

	ultrasonic_echo_ranger #(
		.COUNT_WIDTH(CNT_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_req  (start_req),
		.echo       (echo),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.trigger_out(trigger_out),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.distance_cm(distance_cm),
		.pulse_ticks(pulse_ticks),
		.overflow   (overflow),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	// one tick of the ranging sequence; outputs show the state after the update
	function automatic tick_result_t advance_ranger(input logic st, input logic ec);
		tick_result_t r;
		logic [63:0]  product;
		logic [63:0]  quot;
		r = '0;
		case (rng_phase)
			RNG_IDLE: begin
				if (st) begin
					rng_phase = RNG_TRIG;
					trig_count = '0;
				end
			end
			RNG_TRIG: begin
				// 16-bit count wraps; a length of zero ends after one tick
				trig_count = trig_count + 1'b1;
				if (trig_count >= trig_len)
					rng_phase = RNG_WAIT;
			end
			RNG_WAIT: begin
				// only a true rising edge starts the width count
				if (ec && !echo_last) begin
					rng_phase = RNG_MEAS;
					width_count = 32'd1;
				end
			end
			default: begin
				if (ec) begin
					if (width_count < WIDTH_SAT)
						width_count = width_count + 32'd1;
				end else begin
					// falling edge: scale, saturate and latch
					if (divisor == '0) begin
						dist_hold = uer_pkg::DIST_MAX;
					end else begin
						product = 64'(width_count) * 64'(speed);
						quot = product / 64'(divisor);
						dist_hold = (quot > 64'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
							: quot[uer_pkg::DIST_W-1:0];
					end
					ovf_hold = (width_count >= WIDTH_SAT);
					r.done = 1'b1;
					rng_phase = RNG_IDLE;
				end
			end
		endcase
		echo_last = ec;
		r.trig = (rng_phase == RNG_TRIG);
		r.busy = (rng_phase != RNG_IDLE);
		r.distance = dist_hold;
		r.pulse = (width_count > 32'(uer_pkg::PULSE_MAX)) ? uer_pkg::PULSE_MAX
			: width_count[uer_pkg::PULSE_W-1:0];
		r.ovf = ovf_hold;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got)
			flag_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	// driver: new item or idle at the falling edge, payload held while stalled
	always @(negedge clk) begin
		// toggle stretches with no idling at all
		if ($urandom_range(0, 63) == 0)
			calm = !calm;
		if (arst_n) begin
			out_stall <= !calm && ($urandom_range(0, 99) < stall_pct);
			if (!in_valid || in_taken) begin
				if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= gap_pct)) begin
					next_tick = tick_q.pop_front();
					in_valid <= 1'b1;
					start_req <= next_tick.start;
					echo <= next_tick.echo;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on item acceptance, then compare against the oldest prediction
	always @(posedge clk) begin : monitor
		tick_result_t want_r;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				predicted_q.push_back(advance_ranger(start_req, echo));
			end
			if (out_valid && !out_stall) begin
				if (predicted_q.size() == 0) begin
					flag_mismatch("result item with no prediction waiting");
				end else begin
					want_r = predicted_q.pop_front();
					check_field("trigger_out", want_r.trig, trigger_out);
					check_field("busy_res", want_r.busy, busy_res);
					check_field("done_res", want_r.done, done_res);
					check_field("distance_cm", want_r.distance, distance_cm);
					check_field("pulse_ticks", want_r.pulse, pulse_ticks);
					check_field("overflow", want_r.ovf, overflow);
				end
			end
		end
	end

	task automatic push_tick(input logic st, input logic ec);
		tick_t t;
		t.start = st;
		t.echo = ec;
		tick_q.push_back(t);
		ticks_queued++;
	endtask

	// one measurement: start, trigger noise, optional held-high echo, low gap,
	// echo pulse and falling edge; start requests while busy are sprinkled in
	task automatic push_ping(input int held_high, input int low_len, input int high_len);
		int trig_eff;
		trig_eff = (trig_len == '0) ? 1 : int'(trig_len);
		push_tick(1'b1, 1'($urandom_range(0, 1)));
		repeat (trig_eff)
			push_tick(1'($urandom_range(0, 1)),
				(held_high > 0) ? 1'b1 : 1'($urandom_range(0, 1)));
		repeat (held_high)
			push_tick(1'($urandom_range(0, 1)), 1'b1);
		repeat (low_len)
			push_tick(1'($urandom_range(0, 1)), 1'b0);
		repeat (high_len)
			push_tick(1'($urandom_range(0, 1)), 1'b1);
		push_tick(1'($urandom_range(0, 1)), 1'b0);
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || in_valid || predicted_q.size() != 0)
			@(posedge clk);
	endtask

	// bring the block back to idle with nothing in flight
	task automatic settle();
		int trig_eff;
		wait_drained();
		if (rng_phase != RNG_IDLE) begin
			trig_eff = (trig_len == '0) ? 1 : int'(trig_len);
			if (rng_phase == RNG_TRIG)
				repeat (trig_eff - int'(trig_count))
					push_tick(1'b0, 1'b0);
			// clears a held echo, then a short pulse ends any waiting measurement
			push_tick(1'b0, 1'b0);
			push_tick(1'b0, 1'b1);
			push_tick(1'b0, 1'b0);
			wait_drained();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
			input logic [uer_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			uer_pkg::REG_TRIGGER_TICKS: trig_len = val[uer_pkg::TRIG_W-1:0];
			uer_pkg::REG_SPEED_FACTOR:  speed = val[uer_pkg::SPEED_W-1:0];
			uer_pkg::REG_SCALE_DIVISOR: divisor = val[uer_pkg::DIV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [uer_pkg::CFG_DATA_W-1:0] t_data,
			input logic [uer_pkg::CFG_DATA_W-1:0] s_data,
			input logic [uer_pkg::CFG_DATA_W-1:0] d_data, input logic spare);
		write_reg(uer_pkg::REG_TRIGGER_TICKS, t_data);
		write_reg(uer_pkg::REG_SPEED_FACTOR, s_data);
		write_reg(uer_pkg::REG_SCALE_DIVISOR, d_data);
		if (spare)
			write_reg(REG_SPARE, uer_pkg::CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset release on a falling edge, after the driver has already run at that edge
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// stimulus: directed cases first, then random phases
	initial begin : stimulus
		logic [uer_pkg::CFG_DATA_W-1:0] d_data;
		int sel;
		int roll;
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// reset register values, idle ticks with echo high, a plain measurement
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		push_ping(0, 3, 10);
		// echo still high from the trigger: the held level must not count
		push_ping(4, 2, 6);
		settle();

		// trigger length zero (upper data bits dropped), full speed, unit divisor:
		// distance saturates; then a small in-range distance
		program_regs(20'hF0000, 20'hFFFFF, 20'd1, 1'b1);
		push_ping(0, 2, 70);
		push_ping(0, 1, 1);
		settle();

		// divisor zero
		program_regs(20'd1, 20'd343, 20'd0, 1'b0);
		push_ping(0, 1, 5);
		settle();

		// speed zero, and a long wait with no echo before it finally comes
		program_regs(20'd2, 20'd0, 20'd1, 1'b0);
		push_ping(0, 50, 3);
		settle();

		// long trigger, largest divisor
		program_regs(20'd120, 20'd1023, 20'hFFFFF, 1'b0);
		push_ping(0, 2, 250);
		settle();

		// random phases, each over several register settings
		for (int p = 0; p < 4; p++) begin
			gap_pct = gap_plan[p];
			stall_pct = stall_plan[p];
			for (int b = 0; b < 4; b++) begin
				settle();
				sel = $urandom_range(0, 7);
				if (sel == 0)
					d_data = '0;
				else if (sel < 4)
					d_data = uer_pkg::CFG_DATA_W'($urandom_range(1, 4000));
				else
					d_data = uer_pkg::CFG_DATA_W'($urandom);
				program_regs({4'($urandom_range(0, 15)), 16'($urandom_range(0, 6))},
					uer_pkg::CFG_DATA_W'($urandom), d_data, $urandom_range(0, 3) == 0);
				ticks_queued = 0;
				while (ticks_queued < 30) begin
					roll = $urandom_range(0, 99);
					if (roll < 85) begin
						push_ping(($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0,
							($urandom_range(0, 7) == 0) ? $urandom_range(7, 30)
								: $urandom_range(1, 6),
							($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
								: $urandom_range(1, 40));
					end else begin
						// noise and broken sequences
						repeat ($urandom_range(1, 12))
							push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					end
				end
			end
		end

		settle();
		if (predicted_q.size() != 0)
			flag_mismatch($sformatf("%0d predicted result items never arrived",
				predicted_q.size()));
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/uer_pkg.sv
design/uer_div.sv
design/ultrasonic_echo_ranger.sv
design/uer_checker.sv
tb/tb_ultrasonic_echo_ranger.sv
